FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the timer RTL; clk and rst are taken from the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Checked only outside reset.
`define TMR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked at every edge, reset included.
`define TMR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TMR_ASSERT(label, prop, msg)
`define TMR_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

FILE: rtl/core/tmr_pkg.sv
// Shared types and constants for the up-counting PWM timer.
package tmr_pkg;

  localparam int CMD_W  = 2;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 16;

  // Item commands
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

  // Register map
  localparam logic [ADDR_W-1:0] REG_CTRL     = 4'd0;
  localparam logic [ADDR_W-1:0] REG_STATUS   = 4'd1;
  localparam logic [ADDR_W-1:0] REG_EVENT    = 4'd2;
  localparam logic [ADDR_W-1:0] REG_CMP_MODE = 4'd3;
  localparam logic [ADDR_W-1:0] REG_CH_EN    = 4'd4;
  localparam logic [ADDR_W-1:0] REG_COUNT    = 4'd5;
  localparam logic [ADDR_W-1:0] REG_PSC      = 4'd6;
  localparam logic [ADDR_W-1:0] REG_RELOAD   = 4'd7;
  localparam logic [ADDR_W-1:0] REG_COMPARE  = 4'd8;
  localparam logic [ADDR_W-1:0] REG_MAIN_OUT = 4'd9;

  // Bit positions
  localparam int CTRL_EN_BIT   = 0;
  localparam int CTRL_ARPE_BIT = 7;
  localparam int UIF_BIT       = 0;
  localparam int UG_BIT        = 0;
  localparam int CMP_PE_BIT    = 3;
  localparam int MODE_LSB      = 4;
  localparam int CH_EN_BIT     = 0;
  localparam int MOE_BIT       = 15;

  // Compare modes
  localparam logic [2:0] MODE_PWM1 = 3'd6;
  localparam logic [2:0] MODE_PWM2 = 3'd7;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [ADDR_W-1:0] reg_addr;
    logic [DATA_W-1:0] write_data;
  } item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              pwm_out;
    logic              update_flag;
  } result_t;

endpackage

FILE: rtl/core/tmr_req_if.sv
// Request channel: one tick, register write or register read per transfer.
interface tmr_req_if;
  import tmr_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [ADDR_W-1:0] reg_addr;
  logic [DATA_W-1:0] write_data;

  modport source (output valid, command, reg_addr, write_data, input ready);
  modport sink   (input valid, command, reg_addr, write_data, output ready);
endinterface

FILE: rtl/core/tmr_rsp_if.sv
// Response channel: read data and output levels after each request.
interface tmr_rsp_if;
  import tmr_pkg::*;

  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_data;
  logic              pwm_out;
  logic              update_flag;

  modport source (output valid, read_data, pwm_out, update_flag, input ready);
  modport sink   (input valid, read_data, pwm_out, update_flag, output ready);
endinterface

FILE: rtl/core/tmr_core.sv
// Timer state, register bank and single-pass next-state / result logic.
`include "assert_macros.svh"

module tmr_core #(
  parameter int COUNTER_WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  tmr_pkg::item_t   item,
  output tmr_pkg::result_t result
);
  import tmr_pkg::*;

  localparam int W = COUNTER_WIDTH;

  // Control bits
  logic counter_enable, counter_enable_next;
  logic reload_preload_on, reload_preload_on_next;
  logic update_pending, update_pending_next;
  logic [2:0] compare_mode, compare_mode_next;
  logic compare_preload_on, compare_preload_on_next;
  logic channel_enable, channel_enable_next;
  logic main_output_enable, main_output_enable_next;

  // Counts and their written / active copies
  logic [W-1:0] count_value, count_value_next;
  logic [W-1:0] prescale_count, prescale_count_next;
  logic [W-1:0] prescaler_written, prescaler_written_next;
  logic [W-1:0] prescaler_active, prescaler_active_next;
  logic [W-1:0] reload_written, reload_written_next;
  logic [W-1:0] reload_active, reload_active_next;
  logic [W-1:0] compare_written, compare_written_next;
  logic [W-1:0] compare_active, compare_active_next;

  logic [W+DATA_W-1:0] wd_ext;
  logic [W-1:0]        wd;
  logic [W+DATA_W-1:0] rd_ext;
  logic                do_update;
  logic [DATA_W-1:0]   rd;
  logic                below;
  logic                level;

  // Write data resized to the counter width
  assign wd_ext = {{W{1'b0}}, item.write_data};
  assign wd     = wd_ext[W-1:0];

  // Next state
  always_comb begin
    counter_enable_next     = counter_enable;
    reload_preload_on_next  = reload_preload_on;
    update_pending_next     = update_pending;
    compare_mode_next       = compare_mode;
    compare_preload_on_next = compare_preload_on;
    channel_enable_next     = channel_enable;
    main_output_enable_next = main_output_enable;
    count_value_next        = count_value;
    prescale_count_next     = prescale_count;
    prescaler_written_next  = prescaler_written;
    prescaler_active_next   = prescaler_active;
    reload_written_next     = reload_written;
    reload_active_next      = reload_active;
    compare_written_next    = compare_written;
    compare_active_next     = compare_active;
    do_update               = 1'b0;

    case (item.command)
      CMD_TICK: begin
        if (counter_enable) begin
          if (prescale_count != prescaler_active) begin
            prescale_count_next = prescale_count + 1'b1;
          end else begin
            prescale_count_next = '0;
            if (count_value == reload_active) begin
              do_update = 1'b1;
            end else begin
              count_value_next = count_value + 1'b1;
            end
          end
        end
      end
      CMD_WRITE: begin
        case (item.reg_addr)
          REG_CTRL: begin
            counter_enable_next    = item.write_data[CTRL_EN_BIT];
            reload_preload_on_next = item.write_data[CTRL_ARPE_BIT];
          end
          REG_STATUS: begin
            if (!item.write_data[UIF_BIT]) update_pending_next = 1'b0;
          end
          REG_EVENT: begin
            do_update = item.write_data[UG_BIT];
          end
          REG_CMP_MODE: begin
            compare_mode_next       = item.write_data[MODE_LSB +: 3];
            compare_preload_on_next = item.write_data[CMP_PE_BIT];
          end
          REG_CH_EN: begin
            channel_enable_next = item.write_data[CH_EN_BIT];
          end
          REG_COUNT: begin
            count_value_next = wd;
          end
          REG_PSC: begin
            prescaler_written_next = wd;
          end
          REG_RELOAD: begin
            reload_written_next = wd;
            if (!reload_preload_on) reload_active_next = wd;
          end
          REG_COMPARE: begin
            compare_written_next = wd;
            if (!compare_preload_on) compare_active_next = wd;
          end
          REG_MAIN_OUT: begin
            main_output_enable_next = item.write_data[MOE_BIT];
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase

    // Update event: restart counts, load shadows, raise flag
    if (do_update) begin
      count_value_next      = '0;
      prescale_count_next   = '0;
      prescaler_active_next = prescaler_written;
      reload_active_next    = reload_written;
      compare_active_next   = compare_written;
      update_pending_next   = 1'b1;
    end
  end

  // Read mux (state is unchanged by a read)
  always_comb begin
    rd = '0;
    rd_ext = '0;
    if (item.command == CMD_READ) begin
      case (item.reg_addr)
        REG_CTRL: begin
          rd[CTRL_EN_BIT]   = counter_enable;
          rd[CTRL_ARPE_BIT] = reload_preload_on;
        end
        REG_STATUS: rd[UIF_BIT] = update_pending;
        REG_CMP_MODE: begin
          rd[MODE_LSB +: 3] = compare_mode;
          rd[CMP_PE_BIT]    = compare_preload_on;
        end
        REG_CH_EN:    rd[CH_EN_BIT] = channel_enable;
        REG_COUNT: begin
          rd_ext = {{DATA_W{1'b0}}, count_value};
          rd     = rd_ext[DATA_W-1:0];
        end
        REG_PSC: begin
          rd_ext = {{DATA_W{1'b0}}, prescaler_written};
          rd     = rd_ext[DATA_W-1:0];
        end
        REG_RELOAD: begin
          rd_ext = {{DATA_W{1'b0}}, reload_written};
          rd     = rd_ext[DATA_W-1:0];
        end
        REG_COMPARE: begin
          rd_ext = {{DATA_W{1'b0}}, compare_written};
          rd     = rd_ext[DATA_W-1:0];
        end
        REG_MAIN_OUT: rd[MOE_BIT] = main_output_enable;
        default: rd = '0;
      endcase
    end
  end

  // PWM level from the state after this item
  always_comb begin
    below = count_value_next < compare_active_next;
    case (compare_mode_next)
      MODE_PWM1: level = below;
      MODE_PWM2: level = !below;
      default:   level = 1'b0;
    endcase
  end

  assign result.read_data   = rd;
  assign result.pwm_out     = level & channel_enable_next & main_output_enable_next;
  assign result.update_flag = update_pending_next;

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      counter_enable     <= 1'b0;
      reload_preload_on  <= 1'b0;
      update_pending     <= 1'b0;
      compare_mode       <= '0;
      compare_preload_on <= 1'b0;
      channel_enable     <= 1'b0;
      main_output_enable <= 1'b0;
      count_value        <= '0;
      prescale_count     <= '0;
      prescaler_written  <= '0;
      prescaler_active   <= '0;
      reload_written     <= '1;
      reload_active      <= '1;
      compare_written    <= '0;
      compare_active     <= '0;
    end else if (step) begin
      counter_enable     <= counter_enable_next;
      reload_preload_on  <= reload_preload_on_next;
      update_pending     <= update_pending_next;
      compare_mode       <= compare_mode_next;
      compare_preload_on <= compare_preload_on_next;
      channel_enable     <= channel_enable_next;
      main_output_enable <= main_output_enable_next;
      count_value        <= count_value_next;
      prescale_count     <= prescale_count_next;
      prescaler_written  <= prescaler_written_next;
      prescaler_active   <= prescaler_active_next;
      reload_written     <= reload_written_next;
      reload_active      <= reload_active_next;
      compare_written    <= compare_written_next;
      compare_active     <= compare_active_next;
    end
  end

  // Checks
  `TMR_ASSERT(a_hold_when_idle,
    !step |=> $stable(count_value) && $stable(prescale_count),
    "counts moved without a transfer")
  `TMR_ASSERT(a_disabled_tick,
    step && item.command == CMD_TICK && !counter_enable |=>
      $stable(count_value) && $stable(update_pending),
    "disabled counter advanced")
  `TMR_ASSERT(a_event_sets_flag,
    step && item.command == CMD_WRITE && item.reg_addr == REG_EVENT &&
      item.write_data[UG_BIT] |=>
      update_pending && count_value == '0 && prescale_count == '0,
    "update event not taken")
  `TMR_ASSERT(a_flag_clear,
    step && item.command == CMD_WRITE && item.reg_addr == REG_STATUS &&
      !item.write_data[UIF_BIT] |=> !update_pending,
    "update flag not cleared")

endmodule

FILE: rtl/core/up_counting_pwm_timer.sv
// Top level of the up-counting PWM timer: input register, core and output register.
//
// Up-counting timer with one PWM channel behind a 10-register bank. Each request is
// a tick, a register write or a register read, and each produces exactly one response
// with the read data (zero unless a read), the PWM output level and the update flag as
// they stand after that request. The block takes one request per clock sustained while the
// response side keeps rsp.ready high; back-pressure there stalls the input register. Each
// request passes through the input register and then the output register, with the single
// pass of next-state logic between them. COUNTER_WIDTH sizes the count, prescaler, reload and compare
// registers; writes are zero-extended or truncated to it and reads return its low 16 bits.
`include "assert_macros.svh"

module up_counting_pwm_timer #(
  parameter int COUNTER_WIDTH = 16
) (
  input logic       clk,
  input logic       rst,
  tmr_req_if.sink   req,
  tmr_rsp_if.source rsp
);
  import tmr_pkg::*;

  logic    in_valid;
  item_t   in_item;
  logic    out_valid;
  result_t out_result;
  result_t core_result;
  logic    advance;

  // Move the held request into the core when the output slot is free
  assign advance   = in_valid && (!out_valid || rsp.ready);
  assign req.ready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_item.command    <= req.command;
      in_item.reg_addr   <= req.reg_addr;
      in_item.write_data <= req.write_data;
    end
  end

  tmr_core #(
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .item   (in_item),
    .result (core_result)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= core_result;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.read_data   = out_result.read_data;
  assign rsp.pwm_out     = out_result.pwm_out;
  assign rsp.update_flag = out_result.update_flag;

  // Checks
  `TMR_ASSERT(a_no_overwrite, out_valid && !rsp.ready |-> !advance, "response overwritten")
  `TMR_ASSERT(a_held_request, in_valid && !advance |=> in_valid && $stable(in_item), "held request lost")
  `TMR_ASSERT_ALWAYS(a_reset_empty, rst |=> !in_valid && !out_valid, "pipeline not empty after reset")

endmodule
